[rtl/htu_pkg.sv]
// Shared types, constants and a helper function of the homogeneous transform unit.
`default_nettype none

package htu_pkg;

   // Fixed-point format and geometry
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int LANES      = 4;
   localparam int LANE_IDX_W = $clog2(LANES);
   localparam int OPCODE_W   = 2;
   localparam int PROD_W     = 2 * DATA_W - FRAC_BITS;
   localparam int SUM_W      = PROD_W + 2;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_IDENTITY  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TRANSLATE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_SCALE     = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_TRANSFORM = 2'd3;

   typedef logic signed [DATA_W-1:0]   data_type;
   typedef logic signed [2*DATA_W-1:0] full_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [OPCODE_W-1:0]        opcode_type;

   localparam data_type FX_ONE = data_type'(1 << FRAC_BITS);
   localparam data_type FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Lane control, driven by the top level
   typedef struct packed {
      logic       identity;  // load the identity row this cycle
      logic       load;      // capture products into the multiply stage
      opcode_type op_s0;     // opcode of the item being accepted
      logic       commit;    // multiply stage retires this cycle
      opcode_type op_s1;     // opcode held in the multiply stage
   } lane_ctrl_type;

   // Clamp a wide sum to the signed data range
   function automatic data_type sat_data(input sum_type v);
      data_type r;
      if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
         r = v[DATA_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = FX_MIN;
      end else begin
         r = FX_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/htu_req_if.sv]
// Request channel interface: opcode and the four operand components.
`default_nettype none

interface htu_req_if import htu_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   data_type   in_x;
   data_type   in_y;
   data_type   in_z;
   data_type   in_w;

   modport source (output valid, opcode, in_x, in_y, in_z, in_w, input ready);
   modport sink   (input valid, opcode, in_x, in_y, in_z, in_w, output ready);
endinterface

`default_nettype wire

[rtl/htu_rsp_if.sv]
// Response channel interface: the transformed vector.
`default_nettype none

interface htu_rsp_if import htu_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type out_x;
   data_type out_y;
   data_type out_z;
   data_type out_w;

   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

`default_nettype wire

[rtl/htu_lane.sv]
// One matrix row: its four entries, four multipliers and the row sum.
`default_nettype none

module htu_lane import htu_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [LANE_IDX_W-1:0] lane_row,
   input  wire lane_ctrl_type         ctrl,
   input  wire data_type              vec [LANES],
   output data_type                   result
);

   data_type row_ff  [LANES];
   prod_type prod_ff [LANES];
   prod_type prod_in [LANES];
   full_type prod_full [LANES];
   full_type prod_shift [LANES];
   data_type operand [LANES];
   sum_type  sum3;
   sum_type  tr_sum;
   sum_type  vec_sum;

   // Multiply each entry by its operand and drop the fraction bits
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         operand[c]    = (ctrl.op_s0 == OP_SCALE) ? vec[lane_row] : vec[c];
         prod_full[c]  = full_type'(row_ff[c]) * full_type'(operand[c]);
         prod_shift[c] = prod_full[c] >>> FRAC_BITS;
         prod_in[c]    = prod_shift[c][PROD_W-1:0];
      end
   end

   // Hold products for the sum stage
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
   end

   // Sum products for translate and vector transform
   always_comb begin
      sum3    = sum_type'(prod_ff[0]) + sum_type'(prod_ff[1]) + sum_type'(prod_ff[2]);
      tr_sum  = sum3 + sum_type'(row_ff[3]);
      vec_sum = sum3 + sum_type'(prod_ff[3]);
      result  = sat_data(vec_sum);
   end

   // Update the row: reset or identity load, or commit of translate / scale
   always_ff @(posedge clock) begin
      if (reset || ctrl.identity) begin
         for (int c = 0; c < LANES; c++) begin
            row_ff[c] <= (LANE_IDX_W'(c) == lane_row) ? FX_ONE : '0;
         end
      end else if (ctrl.commit) begin
         case (ctrl.op_s1)
            OP_TRANSLATE: begin
               row_ff[3] <= sat_data(tr_sum);
            end
            OP_SCALE: begin
               if (lane_row != LANE_IDX_W'(3)) begin
                  for (int c = 0; c < LANES; c++) begin
                     row_ff[c] <= sat_data(sum_type'(prod_ff[c]));
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/htu_merge.sv]
// Output stage: gathers the four lane results into one response register.
`default_nettype none

module htu_merge import htu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire data_type lane_result [LANES],
   output logic          out_free,
   htu_rsp_if.source     rsp_if
);

   logic     out_valid_ff;
   logic     out_valid_in;
   data_type out_data_ff [LANES];

   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign out_valid_in = push || (out_valid_ff && !rsp_if.ready);

   // Track response occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the vector when the sum stage hands one over
   always_ff @(posedge clock) begin
      if (push) begin
         out_data_ff <= lane_result;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.out_x = out_data_ff[0];
   assign rsp_if.out_y = out_data_ff[1];
   assign rsp_if.out_z = out_data_ff[2];
   assign rsp_if.out_w = out_data_ff[3];

endmodule

`default_nettype wire

[rtl/homogeneous_transform_unit_top.sv]
// Top level of the homogeneous transform unit: four row lanes and the output stage.
`default_nettype none

// Holds a 4x4 Q16.16 transform matrix, one row per lane, and applies identity,
// translate, scale or vector-transform requests. Each lane multiplies its row
// by the operands (four 32x32 multipliers per lane) into the multiply stage;
// the sum stage then sums, saturates and either updates the matrix or hands
// the vector to the response register. Transforms and identity loads are taken
// one per cycle while the response side does not stall. A translate or scale
// blocks the next request until its matrix update has landed. Backpressure on
// the response side stalls the multiply stage only when it holds a transform.

module homogeneous_transform_unit_top import htu_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   htu_req_if.sink   req_if,
   htu_rsp_if.source rsp_if
);

   logic          s1_valid_ff;
   logic          s1_valid_in;
   opcode_type    s1_op_ff;
   logic          s1_move;
   logic          s1_open;
   logic          req_fire;
   logic          out_free;
   logic          push;
   lane_ctrl_type ctrl;
   data_type      vec [LANES];
   data_type      lane_result [LANES];

   // Multiply stage advances unless a transform waits on a full output
   assign s1_move  = (s1_op_ff != OP_TRANSFORM) || out_free;
   assign s1_open  = !s1_valid_ff || s1_move;
   assign req_if.ready = !reset &&
                         (!s1_valid_ff || ((s1_op_ff == OP_TRANSFORM) && out_free));
   assign req_fire = req_if.valid && req_if.ready;
   assign s1_valid_in = req_fire && (req_if.opcode != OP_IDENTITY);
   assign push = s1_valid_ff && (s1_op_ff == OP_TRANSFORM) && s1_move;

   // Advance the multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_open) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open) begin
         s1_op_ff <= req_if.opcode;
      end
   end

   // Lane control
   always_comb begin
      ctrl.identity = req_fire && (req_if.opcode == OP_IDENTITY);
      ctrl.load     = req_fire;
      ctrl.op_s0    = req_if.opcode;
      ctrl.commit   = s1_valid_ff && s1_move;
      ctrl.op_s1    = s1_op_ff;
   end

   assign vec[0] = req_if.in_x;
   assign vec[1] = req_if.in_y;
   assign vec[2] = req_if.in_z;
   assign vec[3] = req_if.in_w;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      htu_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .lane_row (LANE_IDX_W'(g)),
         .ctrl     (ctrl),
         .vec      (vec),
         .result   (lane_result[g])
      );
   end

   htu_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .lane_result (lane_result),
      .out_free    (out_free),
      .rsp_if      (rsp_if)
   );

endmodule

`default_nettype wire

[rtl/htu_checker.sv]
// Port-level checks of the homogeneous transform unit, bound to the top level.
`default_nettype none

module htu_checker import htu_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire opcode_type req_opcode,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire data_type   rsp_x,
   input wire data_type   rsp_y,
   input wire data_type   rsp_z,
   input wire data_type   rsp_w
);

   // A stalled response holds its vector
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x) && $stable(rsp_y)
         && $stable(rsp_z) && $stable(rsp_w))
      else $error("stalled response changed");

   // A matrix update keeps the request side not ready in the following cycle
   a_update_block: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_TRANSLATE || req_opcode == OP_SCALE)
         |=> !req_ready)
      else $error("request taken during matrix update");

   // A fresh response comes from a transform request that passed the multiply stage
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_opcode == OP_TRANSFORM, 2))
      else $error("response without transform request");

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind homogeneous_transform_unit_top htu_checker u_htu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .req_opcode (req_if.opcode),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_x      (rsp_if.out_x),
   .rsp_y      (rsp_if.out_y),
   .rsp_z      (rsp_if.out_z),
   .rsp_w      (rsp_if.out_w)
);

`default_nettype wire

[test/testbench.sv]
// Testbench for the homogeneous transform unit: directed rows, then random opcode sequences.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import htu_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int ITEM_COUNT   = 1900;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 34;

   typedef struct {
      opcode_type opcode;
      data_type   x, y, z, w;
      bit         literal;      // expected vector typed in below
      data_type   ex, ey, ez, ew;
   } stim_row_type;

   typedef struct packed {
      data_type x, y, z, w;
   } vec4_type;

   logic clock = 1'b0;
   logic reset;

   htu_req_if req_ch ();
   htu_rsp_if rsp_ch ();

   homogeneous_transform_unit_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Shadow matrix, column-major: entry (col, row) at col*4+row
   data_type     mat_shadow[16];
   vec4_type     vectors_due[$];
   stim_row_type directed_rows[$];
   int           mismatches  = 0;
   int           cycle_count = 0;
   int           items_sent  = 0;
   logic         no_idle;

   always #1 clock = ~clock;

   // Q16.16 product, low fraction bits dropped (floor)
   function automatic longint fx_product(input data_type a, input data_type b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC_BITS;
   endfunction

   function automatic data_type fx_clamp(input longint v);
      if (v > longint'(FX_MAX)) begin
         return FX_MAX;
      end
      if (v < longint'(FX_MIN)) begin
         return FX_MIN;
      end
      return data_type'(v);
   endfunction

   function automatic void load_identity();
      for (int k = 0; k < 16; k++) begin
         mat_shadow[k] = '0;
      end
      for (int k = 0; k < 4; k++) begin
         mat_shadow[k*4 + k] = FX_ONE;
      end
   endfunction

   // Apply one request to the shadow matrix; a transform yields a vector
   function automatic void predict_request(input stim_row_type it, output bit emits,
                                           output vec4_type vec);
      data_type v[4];
      longint   acc[4];
      v[0] = it.x;
      v[1] = it.y;
      v[2] = it.z;
      v[3] = it.w;
      emits = 1'b0;
      vec   = '0;
      case (it.opcode)
         OP_IDENTITY: begin
            load_identity();
         end
         OP_TRANSLATE: begin
            for (int r = 0; r < 4; r++) begin
               acc[r] = longint'(mat_shadow[12 + r]);
               for (int c = 0; c < 3; c++) begin
                  acc[r] += fx_product(mat_shadow[c*4 + r], v[c]);
               end
               mat_shadow[12 + r] = fx_clamp(acc[r]);
            end
         end
         OP_SCALE: begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 4; c++) begin
                  mat_shadow[c*4 + r] = fx_clamp(fx_product(mat_shadow[c*4 + r], v[r]));
               end
            end
         end
         default: begin
            for (int r = 0; r < 4; r++) begin
               acc[r] = 0;
               for (int c = 0; c < 4; c++) begin
                  acc[r] += fx_product(mat_shadow[c*4 + r], v[c]);
               end
            end
            emits = 1'b1;
            vec.x = fx_clamp(acc[0]);
            vec.y = fx_clamp(acc[1]);
            vec.z = fx_clamp(acc[2]);
            vec.w = fx_clamp(acc[3]);
         end
      endcase
   endfunction

   function automatic stim_row_type make_row(input opcode_type op, input data_type x,
                                             input data_type y, input data_type z,
                                             input data_type w);
      stim_row_type it;
      it.opcode  = op;
      it.x       = x;
      it.y       = y;
      it.z       = z;
      it.w       = w;
      it.literal = 1'b0;
      it.ex      = '0;
      it.ey      = '0;
      it.ez      = '0;
      it.ew      = '0;
      return it;
   endfunction

   // Transform under the identity matrix: the vector comes back unchanged
   function automatic stim_row_type echo_row(input data_type x, input data_type y,
                                             input data_type z, input data_type w);
      stim_row_type it;
      it         = make_row(OP_TRANSFORM, x, y, z, w);
      it.literal = 1'b1;
      it.ex      = x;
      it.ey      = y;
      it.ez      = z;
      it.ew      = w;
      return it;
   endfunction

   // Mostly moderate factors, some extremes, some full-range words
   function automatic data_type pick_value(input bit wide);
      case ($urandom_range(0, 9))
         0: return data_type'($urandom);
         1: begin
            case ($urandom_range(0, 5))
               0:       return FX_MIN;
               1:       return FX_MAX;
               2:       return '0;
               3:       return -1;
               4:       return FX_ONE;
               default: return -FX_ONE;
            endcase
         end
         default: begin
            if (wide) begin
               return data_type'($urandom);
            end
            return data_type'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         end
      endcase
   endfunction

   // Drive one request, hold it until the transfer, then predict
   task automatic send_request(input stim_row_type it);
      bit       emits;
      vec4_type vec;
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid  <= 1'b0;
         req_ch.opcode <= opcode_type'($urandom);
         req_ch.in_x   <= data_type'($urandom);
         req_ch.in_y   <= data_type'($urandom);
         req_ch.in_z   <= data_type'($urandom);
         req_ch.in_w   <= data_type'($urandom);
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= it.opcode;
      req_ch.in_x   <= it.x;
      req_ch.in_y   <= it.y;
      req_ch.in_z   <= it.z;
      req_ch.in_w   <= it.w;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      predict_request(it, emits, vec);
      if (emits) begin
         if (it.literal) begin
            vec = {it.ex, it.ey, it.ez, it.ew};
         end
         vectors_due.push_back(vec);
      end
      items_sent++;
   endtask

   // Hold the request side until every pending vector has come back
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (vectors_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Random sequences: mostly an identity, a few matrix updates, then a burst of transforms, or a noise row
   task automatic run_random(input int total);
      stim_row_type it;
      int           setups;
      int           vecs;
      bit           paused;
      paused = 1'b0;
      while (items_sent < total) begin
         no_idle <= (items_sent >= 700 && items_sent < 1100);
         if (!paused && items_sent >= 1200) begin
            paused = 1'b1;
            hold_until_drained();
         end
         // noise: any opcode, any data
         if ($urandom_range(0, 9) == 0) begin
            it = make_row(opcode_type'($urandom), data_type'($urandom), data_type'($urandom),
                          data_type'($urandom), data_type'($urandom));
            send_request(it);
            continue;
         end
         if ($urandom_range(0, 9) < 7) begin
            send_request(make_row(OP_IDENTITY, data_type'($urandom), data_type'($urandom),
                                  data_type'($urandom), data_type'($urandom)));
         end
         setups = $urandom_range(0, 3);
         for (int k = 0; k < setups; k++) begin
            it = make_row($urandom_range(0, 1) ? OP_TRANSLATE : OP_SCALE, pick_value(1'b0),
                          pick_value(1'b0), pick_value(1'b0), data_type'($urandom));
            send_request(it);
         end
         vecs = $urandom_range(1, 8);
         for (int k = 0; k < vecs; k++) begin
            it = make_row(OP_TRANSFORM, pick_value(1'($urandom_range(0, 1))),
                          pick_value(1'($urandom_range(0, 1))),
                          pick_value(1'($urandom_range(0, 1))),
                          pick_value(1'($urandom_range(0, 1))));
            send_request(it);
         end
      end
      no_idle <= 1'b0;
   endtask

   task automatic compare_lane(input string lane, input data_type want, input data_type got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on out_%s: expected %0d (0x%08h), got %0d (0x%08h)",
                     lane, want, want, got, got);
         end
      end
   endtask

   // Response side: random backpressure, check each transfer against the oldest vector
   always @(posedge clock) begin
      vec4_type due;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (vectors_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response with no transform pending: 0x%08h 0x%08h 0x%08h 0x%08h",
                        rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.out_w);
            end
         end else begin
            due = vectors_due.pop_front();
            compare_lane("x", due.x, rsp_ch.out_x);
            compare_lane("y", due.y, rsp_ch.out_y);
            compare_lane("z", due.z, rsp_ch.out_z);
            compare_lane("w", due.w, rsp_ch.out_w);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset         <= 1'b1;
      no_idle       <= 1'b0;
      req_ch.valid  <= 1'b0;
      req_ch.opcode <= OP_IDENTITY;
      req_ch.in_x   <= '0;
      req_ch.in_y   <= '0;
      req_ch.in_z   <= '0;
      req_ch.in_w   <= '0;
      load_identity();

      // identity after reset: extremes come back unchanged
      directed_rows.push_back(echo_row(FX_MIN, FX_MAX, '0, -1));
      directed_rows.push_back(echo_row(1, -2, FX_ONE, 32'sh7FFF_0000));
      // scale and translate with in_w left as junk
      directed_rows.push_back(make_row(OP_SCALE, 32'sh0002_0000, 32'sh0000_8000, -FX_ONE,
                                       32'shDEAD_BEEF));
      directed_rows.push_back(make_row(OP_TRANSLATE, 32'sh0001_8000, -32'sh0003_0000,
                                       32'sh0064_0000, 32'sh1234_5678));
      directed_rows.push_back(make_row(OP_TRANSFORM, FX_ONE, FX_ONE, FX_ONE, FX_ONE));
      // output saturation both ways
      directed_rows.push_back(make_row(OP_TRANSFORM, FX_MAX, FX_MAX, FX_MAX, FX_MAX));
      directed_rows.push_back(make_row(OP_TRANSFORM, FX_MIN, FX_MIN, FX_MIN, FX_MIN));
      // identity ignores all data
      directed_rows.push_back(make_row(OP_IDENTITY, -1, -1, -1, -1));
      directed_rows.push_back(echo_row(-FX_ONE, 32'sh1234_5678, -32'sh1234_5678, FX_MAX));
      // matrix saturation through scale
      directed_rows.push_back(make_row(OP_SCALE, FX_MAX, FX_MIN, FX_MAX, '0));
      directed_rows.push_back(make_row(OP_SCALE, FX_MAX, FX_MAX, FX_MIN, '0));
      directed_rows.push_back(make_row(OP_TRANSFORM, 1, 1, 1, 1));
      directed_rows.push_back(make_row(OP_TRANSFORM, FX_ONE, FX_ONE, FX_ONE, FX_ONE));
      // column 3 saturation through translate
      directed_rows.push_back(make_row(OP_TRANSLATE, FX_MAX, FX_MIN, FX_MAX, '0));
      directed_rows.push_back(make_row(OP_TRANSFORM, FX_ONE, -FX_ONE, '0, FX_ONE));
      directed_rows.push_back(make_row(OP_SCALE, '0, '0, '0, FX_MAX));
      directed_rows.push_back(make_row(OP_TRANSFORM, FX_MAX, FX_MIN, FX_MAX, FX_MIN));
      // floor rounding of negative products
      directed_rows.push_back(make_row(OP_IDENTITY, '0, '0, '0, '0));
      directed_rows.push_back(make_row(OP_SCALE, -1, -FX_ONE, 32'sh0000_8000, '0));
      directed_rows.push_back(make_row(OP_TRANSFORM, 3, -3, 32'sh0001_0001, -1));
      directed_rows.push_back(make_row(OP_TRANSLATE, -1, 1, FX_MIN, '0));
      directed_rows.push_back(make_row(OP_TRANSFORM, FX_MIN, FX_MAX, -1, FX_ONE));
      directed_rows.push_back(make_row(OP_IDENTITY, FX_MAX, FX_MIN, FX_MAX, FX_MIN));
      directed_rows.push_back(echo_row('0, '0, '0, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i]);
      end
      hold_until_drained();
      run_random(ITEM_COUNT);
      req_ch.valid <= 1'b0;

      // drain, then allow stray responses to show up
      while (vectors_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
